// ----- design/utf8_stream_validator_top_defines.svh -----
// Assertion macros shared by the validator's RTL files.
`ifndef UTF8_STREAM_VALIDATOR_TOP_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define UTF8V_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define UTF8V_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/utf8v_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam longint MAX_BUFFER_BYTES = 64'd65536;
    localparam logic [15:0] OFFSET_CAP =
        (MAX_BUFFER_BYTES > 64'd65536) ? 16'hFFFF : 16'(MAX_BUFFER_BYTES - 64'd1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [20:0] CP_MIN_2     = 21'h00080;
    localparam logic [20:0] CP_MIN_3     = 21'h00800;
    localparam logic [20:0] CP_MIN_4     = 21'h10000;
    localparam logic [20:0] SURR_LO      = 21'h0D800;
    localparam logic [20:0] SURR_HI      = 21'h0DFFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    typedef enum logic [1:0] {
        KIND_CP  = 2'd0,
        KIND_ERR = 2'd1,
        KIND_END = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ERR,
        TAIL_END
    } t_tail;

    // Results caused by one byte: an optional code point, then an optional
    // closing item (error or end-ok).
    typedef struct packed {
        logic        has_cp;
        logic [20:0] cp;
        t_tail       tail;
        logic [15:0] pos;
    } t_entry;

    // Sequence length from a lead byte; zero for a byte that cannot lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7] == 1'b0)               len = 3'd1;
            else if (b[7:5] == 3'b110)      len = 3'd2;
            else if (b[7:4] == 4'b1110)     len = 3'd3;
            else if (b[7:3] == 5'b11110)    len = 3'd4;
            else                            len = 3'd0;
            return len;
        end
    endfunction

endpackage

// ----- design/utf8v_ifs.sv -----
// ----------------------------------------------------------------------------
// utf8v_ifs
// Valid/ready channels for raw bytes in and decode results out.
// ----------------------------------------------------------------------------
interface utf8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       buffer_end;

    modport source (output valid, output byte_in, output buffer_end, input ready);
    modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

interface utf8v_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [20:0] code_point;
    logic [15:0] bad_position;
    logic        final_result;

    modport source (output valid, output kind, output code_point, output bad_position,
                    output final_result, input ready);
    modport sink   (input valid, input kind, input code_point, input bad_position,
                    input final_result, output ready);
endinterface

// ----- design/utf8v_front.sv -----
// ----------------------------------------------------------------------------
// utf8v_front
// Byte decoder: tracks the open sequence and classifies each byte's results.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_top_defines.svh"

module utf8v_front import utf8v_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8v_in_if.sink    i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [20:0] r_partial, n_partial;
    logic [2:0]  r_seqlen,  n_seqlen;
    logic [1:0]  r_owed,    n_owed;
    logic [15:0] r_cur_off, n_cur_off;
    logic [15:0] r_start,   n_start;
    logic        r_skip,    n_skip;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [2:0]  len;
    logic [20:0] shifted;
    logic [20:0] min_cp;
    logic        err;
    logic [15:0] err_pos;
    t_entry      ent;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.byte_in;
    assign last       = i_in.buffer_end;
    assign len        = lead_length(b);
    assign shifted    = {r_partial[14:0], b[5:0]};

    always_comb begin
        case (r_seqlen)
            3'd2:    min_cp = CP_MIN_2;
            3'd3:    min_cp = CP_MIN_3;
            default: min_cp = CP_MIN_4;
        endcase
    end

    always_comb begin
        n_partial = r_partial;
        n_seqlen  = r_seqlen;
        n_owed    = r_owed;
        n_cur_off = r_cur_off;
        n_start   = r_start;
        n_skip    = r_skip;
        err       = 1'b0;
        err_pos   = '0;
        ent       = '0;
        ent.tail  = TAIL_NONE;

        if (accept) begin
            if (r_cur_off < OFFSET_CAP) begin
                n_cur_off = r_cur_off + 16'd1;
            end
            if (r_skip) begin
                // drop bytes until the buffer's final byte
                if (last) begin
                    n_cur_off = '0;
                    n_start   = '0;
                    n_skip    = 1'b0;
                end
            end else begin
                if (r_owed == 2'd0) begin
                    if (len == 3'd0) begin
                        err     = 1'b1;
                        err_pos = r_cur_off;
                    end else if (len == 3'd1) begin
                        ent.has_cp = 1'b1;
                        ent.cp     = {13'd0, b};
                    end else begin
                        if (len == 3'd2)      n_partial = {16'd0, b[4:0]};
                        else if (len == 3'd3) n_partial = {17'd0, b[3:0]};
                        else                  n_partial = {18'd0, b[2:0]};
                        n_seqlen = len;
                        n_owed   = 2'(len - 3'd1);
                        n_start  = r_cur_off;
                    end
                end else if (b[7:6] != 2'b10) begin
                    err     = 1'b1;
                    err_pos = r_start;
                end else begin
                    n_partial = shifted;
                    n_owed    = r_owed - 2'd1;
                    if (r_owed == 2'd1) begin
                        if (shifted < min_cp || (shifted >= SURR_LO && shifted <= SURR_HI)
                                || shifted > CP_MAX) begin
                            err     = 1'b1;
                            err_pos = r_start;
                        end else begin
                            ent.has_cp = 1'b1;
                            ent.cp     = shifted;
                        end
                        n_partial = '0;
                        n_seqlen  = '0;
                    end
                end

                // truncated sequence at the final byte
                if (!err && last && n_owed != 2'd0) begin
                    err     = 1'b1;
                    err_pos = n_start;
                end

                if (err) begin
                    ent.tail  = TAIL_ERR;
                    ent.pos   = err_pos;
                    n_partial = '0;
                    n_seqlen  = '0;
                    n_owed    = '0;
                    n_skip    = !last;
                    if (last) begin
                        n_cur_off = '0;
                        n_start   = '0;
                    end
                end else if (last) begin
                    ent.tail  = TAIL_END;
                    n_partial = '0;
                    n_seqlen  = '0;
                    n_owed    = '0;
                    n_cur_off = '0;
                    n_start   = '0;
                end
            end
        end
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.has_cp || ent.tail != TAIL_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_seqlen  <= '0;
            r_owed    <= '0;
            r_cur_off <= '0;
            r_start   <= '0;
            r_skip    <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_seqlen  <= n_seqlen;
            r_owed    <= n_owed;
            r_cur_off <= n_cur_off;
            r_start   <= n_start;
            r_skip    <= n_skip;
        end
    end

    `UTF8V_ASSERT(a_owed_in_seq, (r_owed == 2'd0) || (r_seqlen >= 3'd2 && {1'b0, r_owed} < r_seqlen && !r_skip), "owed bytes outside an open sequence")
    `UTF8V_ASSERT(a_off_cap, r_cur_off <= OFFSET_CAP, "offset above its bound")

endmodule

// ----- design/utf8v_queue.sv -----
// ----------------------------------------------------------------------------
// utf8v_queue
// Short FIFO of classified result entries between decoder and output stage.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_top_defines.svh"

module utf8v_queue import utf8v_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count,  n_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `UTF8V_ASSERT(a_full_ptrs, !o_full || (r_wr_ptr == r_rd_ptr), "full queue with unequal pointers")
    `UTF8V_ASSERT_NEXT(a_push_count, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "push lost")

endmodule

// ----- design/utf8v_back.sv -----
// ----------------------------------------------------------------------------
// utf8v_back
// Output stage: holds one entry and sends its results, one per transaction.
// ----------------------------------------------------------------------------
module utf8v_back import utf8v_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_entry,
    output logic        o_pop,
    utf8v_out_if.source o_out
);

    logic        r_pend_cp, n_pend_cp;
    t_tail       r_tail,    n_tail;
    logic [20:0] r_cp,      n_cp;
    logic [15:0] r_pos,     n_pos;

    logic valid;
    logic take;
    logic last_piece;

    assign valid      = r_pend_cp || (r_tail != TAIL_NONE);
    assign take       = valid && o_out.ready;
    assign last_piece = !r_pend_cp || (r_tail == TAIL_NONE);
    assign o_pop      = !i_empty && (!valid || (take && last_piece));

    always_comb begin
        n_pend_cp = r_pend_cp;
        n_tail    = r_tail;
        n_cp      = r_cp;
        n_pos     = r_pos;
        if (o_pop) begin
            n_pend_cp = i_entry.has_cp;
            n_tail    = i_entry.tail;
            n_cp      = i_entry.cp;
            n_pos     = i_entry.pos;
        end else if (take) begin
            if (r_pend_cp) n_pend_cp = 1'b0;
            else           n_tail    = TAIL_NONE;
        end
    end

    always_comb begin
        o_out.valid        = valid;
        o_out.final_result = !r_pend_cp;
        o_out.code_point   = r_pend_cp ? r_cp : '0;
        o_out.bad_position = (!r_pend_cp && r_tail == TAIL_ERR) ? r_pos : '0;
        if (r_pend_cp)               o_out.kind = KIND_CP;
        else if (r_tail == TAIL_ERR) o_out.kind = KIND_ERR;
        else                         o_out.kind = KIND_END;
    end

    always_ff @(posedge i_clk) begin
        r_cp  <= n_cp;
        r_pos <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cp <= 1'b0;
            r_tail    <= TAIL_NONE;
        end else begin
            r_pend_cp <= n_pend_cp;
            r_tail    <= n_tail;
        end
    end

endmodule

// ----- design/utf8_stream_validator_top.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// UTF-8 decoder and validator for a byte stream split into buffers.
// ----------------------------------------------------------------------------
// Feed one byte per transaction on i_in, with buffer_end set on the buffer's
// last byte. The block accepts one byte every clock cycle: the decoder works
// on the byte in the cycle it is accepted and writes its results into a
// four-entry queue. Results leave on o_out one per transaction, so a byte
// that yields two results (a code point that closes a clean buffer, followed
// by the end-ok item) takes two transactions on the output port; the queue
// absorbs such bursts and output stalls, and i_in.ready drops only when it
// is full. Each well-formed sequence yields a code point (kind 0). The first
// malformed sequence of a buffer yields one error item (kind 1) with the
// byte offset of its lead byte and final_result set; the rest of that buffer
// is consumed silently. A clean buffer closes with an end-ok item (kind 2).
// Offsets restart at zero for every buffer and saturate at 0xFFFF.
// ----------------------------------------------------------------------------
module utf8_stream_validator_top import utf8v_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8v_in_if.sink    i_in,
    utf8v_out_if.source o_out
);

    // decoder -> queue
    logic   push;
    t_entry push_entry;
    logic   full;

    // queue -> output stage
    logic   pop;
    t_entry pop_entry;
    logic   empty;

    // Classify each accepted byte and advance the sequence state.
    utf8v_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // Hold classified results until the output stage takes them.
    utf8v_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    // Send each entry's results in order, code point first.
    utf8v_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- dv/utf8_stream_validator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_top_tb
// Self-checking bench for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
// Bytes go in on i_in. A behavioral decoder predicts the result transactions
// of each accepted byte. A scoreboard compares every result on o_out, field by
// field, with the oldest prediction. The run covers directed boundary and
// malformed buffers and a random mix of mostly well-formed buffers. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module utf8_stream_validator_top_tb;
    import utf8v_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_BYTES   = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 20;

    // Smallest scalar value that each sequence length may encode, the surrogate range and the largest scalar.
    localparam logic [20:0] MIN_TWO_BYTE   = 21'h00080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h00800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h10000;
    localparam logic [20:0] SURROGATE_LO   = 21'h0D800;
    localparam logic [20:0] SURROGATE_HI   = 21'h0DFFF;
    localparam logic [20:0] SCALAR_MAX     = 21'h10FFFF;

    // Random sequence categories for the buffer builder.
    typedef enum int {
        SEQ_ASCII,
        SEQ_TWO,
        SEQ_THREE,
        SEQ_FOUR,
        SEQ_OVERLONG,
        SEQ_SURROGATE,
        SEQ_ABOVE_MAX,
        SEQ_BAD_LEAD,
        SEQ_BAD_CONT,
        SEQ_CUT
    } t_seq_kind;

    typedef struct {
        t_kind       kind;
        logic [20:0] code_point;
        logic [15:0] bad_position;
        logic        final_result;
    } t_decode_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8v_in_if  in_ch();
    utf8v_out_if out_ch();

    utf8_stream_validator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Decoder state mirrored by the bench.
    logic [20:0] dec_value;
    logic [2:0]  dec_len;
    logic [1:0]  dec_owed;
    logic [15:0] byte_offset;
    logic [15:0] seq_start;
    bit          in_skip;

    t_decode_result pending_results[$];

    bit in_idle_on;
    bit out_stall_on;
    int stall_left;
    int quiet_cycles;

    int error_count;
    int bytes_sent;
    int live_bytes;
    int buffers_sent;
    int cp_seen;
    int err_seen;
    int end_seen;

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void push_result(t_kind kind, logic [20:0] cp, logic [15:0] pos,
                                        logic fin);
        t_decode_result r;
        r.kind         = kind;
        r.code_point   = cp;
        r.bad_position = pos;
        r.final_result = fin;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_decoder();
        dec_value   = '0;
        dec_len     = '0;
        dec_owed    = '0;
        byte_offset = '0;
        seq_start   = '0;
        in_skip     = 1'b0;
    endfunction

    // Advance the decoder by one byte and queue the results it yields.
    function automatic void decode_byte(logic [7:0] b, logic last);
        logic [15:0] here;
        logic [2:0]  len;
        logic [20:0] floor_cp;
        bit          fault;
        logic [15:0] fault_at;
        here     = byte_offset;
        fault    = 1'b0;
        fault_at = '0;
        if (byte_offset < OFFSET_CAP) byte_offset++;

        // Drop everything up to the final byte once the buffer has failed.
        if (in_skip) begin
            if (last) clear_decoder();
            return;
        end
        live_bytes++;

        if (dec_owed == 2'd0) begin
            casez (b)
                8'b0???????: len = 3'd1;
                8'b110?????: len = 3'd2;
                8'b1110????: len = 3'd3;
                8'b11110???: len = 3'd4;
                default:     len = 3'd0;
            endcase
            if (len == 3'd0) begin
                fault    = 1'b1;
                fault_at = here;
            end else if (len == 3'd1) begin
                push_result(KIND_CP, {13'd0, b}, 16'd0, 1'b0);
            end else begin
                case (len)
                    3'd2:    dec_value = {16'd0, b[4:0]};
                    3'd3:    dec_value = {17'd0, b[3:0]};
                    default: dec_value = {18'd0, b[2:0]};
                endcase
                dec_len   = len;
                dec_owed  = 2'(len - 3'd1);
                seq_start = here;
            end
        end else if (b[7:6] != 2'b10) begin
            fault    = 1'b1;
            fault_at = seq_start;
        end else begin
            dec_value = {dec_value[14:0], b[5:0]};
            dec_owed--;
            if (dec_owed == 2'd0) begin
                floor_cp = (dec_len == 3'd2) ? MIN_TWO_BYTE :
                           (dec_len == 3'd3) ? MIN_THREE_BYTE : MIN_FOUR_BYTE;
                if (dec_value < floor_cp || dec_value > SCALAR_MAX ||
                    (dec_value >= SURROGATE_LO && dec_value <= SURROGATE_HI)) begin
                    fault    = 1'b1;
                    fault_at = seq_start;
                end else begin
                    push_result(KIND_CP, dec_value, 16'd0, 1'b0);
                end
                dec_value = '0;
                dec_len   = '0;
            end
        end

        // A final byte that leaves continuation bytes owed truncates the sequence.
        if (!fault && last && dec_owed != 2'd0) begin
            fault    = 1'b1;
            fault_at = seq_start;
        end

        if (fault) begin
            push_result(KIND_ERR, 21'd0, fault_at, 1'b1);
            if (last) begin
                clear_decoder();
            end else begin
                in_skip   = 1'b1;
                dec_value = '0;
                dec_len   = '0;
                dec_owed  = '0;
            end
        end else if (last) begin
            push_result(KIND_END, 21'd0, 16'd0, 1'b1);
            clear_decoder();
        end
    endfunction

    // Offer one byte, hold it until accepted, then maybe idle.
    // Call right after a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        in_ch.valid      <= 1'b1;
        in_ch.byte_in    <= b;
        in_ch.buffer_end <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_byte(b, last);
        bytes_sent++;
        if (last) buffers_sent++;
        gap = in_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_buffer(input logic [7:0] buf_bytes[$]);
        foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
    endtask

    // Append the encoding of cp in len bytes, whatever cp's size.
    task automatic encode_seq(ref logic [7:0] q[$], input logic [20:0] cp, input int len);
        case (len)
            1: q.push_back({1'b0, cp[6:0]});
            2: begin
                q.push_back({3'b110, cp[10:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                q.push_back({4'b1110, cp[15:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                q.push_back({5'b11110, cp[20:18]});
                q.push_back({2'b10, cp[17:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // A valid scalar value of the given length, surrogates excluded.
    function automatic logic [20:0] pick_scalar(int len);
        logic [20:0] cp;
        case (len)
            2:       cp = 21'($urandom_range(32'h80, 32'h7FF));
            3: begin
                cp = 21'($urandom_range(32'h800, 32'hFFFF));
                if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp - 21'h800;
            end
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        return cp;
    endfunction

    function automatic t_seq_kind pick_seq_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return SEQ_ASCII;
        if (r < 45) return SEQ_TWO;
        if (r < 60) return SEQ_THREE;
        if (r < 72) return SEQ_FOUR;
        if (r < 76) return SEQ_OVERLONG;
        if (r < 79) return SEQ_SURROGATE;
        if (r < 82) return SEQ_ABOVE_MAX;
        if (r < 87) return SEQ_BAD_LEAD;
        if (r < 93) return SEQ_BAD_CONT;
        return SEQ_CUT;
    endfunction

    // Build one buffer: a run of sequences, mostly well formed.
    task automatic build_buffer(ref logic [7:0] q[$]);
        logic [7:0]  tmp[$];
        logic [20:0] cp;
        int          n_seq;
        int          len;
        int          k;
        q.delete();
        n_seq = $urandom_range(1, 10);
        repeat (n_seq) begin
            tmp.delete();
            len = $urandom_range(2, 4);
            case (pick_seq_kind())
                SEQ_ASCII:     encode_seq(tmp, 21'($urandom_range(0, 127)), 1);
                SEQ_TWO:       encode_seq(tmp, pick_scalar(2), 2);
                SEQ_THREE:     encode_seq(tmp, pick_scalar(3), 3);
                SEQ_FOUR:      encode_seq(tmp, pick_scalar(4), 4);
                SEQ_OVERLONG: begin
                    cp = (len == 2) ? 21'($urandom_range(0, 32'h7F)) :
                         (len == 3) ? 21'($urandom_range(0, 32'h7FF)) :
                                      21'($urandom_range(0, 32'hFFFF));
                    encode_seq(tmp, cp, len);
                end
                SEQ_SURROGATE: encode_seq(tmp, 21'($urandom_range(32'hD800, 32'hDFFF)), 3);
                SEQ_ABOVE_MAX: encode_seq(tmp, 21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
                SEQ_BAD_LEAD: begin
                    if ($urandom_range(0, 1)) tmp.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    else                      tmp.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                end
                SEQ_BAD_CONT: begin
                    encode_seq(tmp, pick_scalar(len), len);
                    k = $urandom_range(1, len - 1);
                    tmp[k] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F)) :
                                                    8'($urandom_range(8'hC0, 8'hFF));
                end
                default: begin
                    // Cut short: truncation at the buffer's end, else a bad continuation.
                    encode_seq(tmp, pick_scalar(len), len);
                    k = $urandom_range(1, len - 1);
                    while (tmp.size() > k) void'(tmp.pop_back());
                end
            endcase
            foreach (tmp[i]) q.push_back(tmp[i]);
        end
    endtask

    task automatic report_field(input string what, input logic [20:0] want,
                                input logic [20:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    // Compare one accepted result transaction with the oldest prediction.
    task automatic check_result();
        t_decode_result want;
        if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: unexpected result, expected none, actual kind %0d cp 0x%0h pos %0d",
                         $time, out_ch.kind, out_ch.code_point, out_ch.bad_position);
        end else begin
            want = pending_results.pop_front();
            if (out_ch.kind !== want.kind)
                report_field("kind", 21'(want.kind), 21'(out_ch.kind));
            if (out_ch.code_point !== want.code_point)
                report_field("code_point", want.code_point, out_ch.code_point);
            if (out_ch.bad_position !== want.bad_position)
                report_field("bad_position", 21'(want.bad_position), 21'(out_ch.bad_position));
            if (out_ch.final_result !== want.final_result)
                report_field("final_result", 21'(want.final_result), 21'(out_ch.final_result));
            case (want.kind)
                KIND_CP:  cp_seen++;
                KIND_ERR: err_seen++;
                default:  end_seen++;
            endcase
        end
    endtask

    // Result side: check each transaction, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_stall_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_results.size());
                $display("utf8_stream_validator_top_tb: done, errors");
                $finish;
            end
        end
    end

    // Boundary values of every length, and a clean end on a completed code point.
    task automatic test_directed_valid();
        logic [7:0] q[$];
        q = '{8'h00, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffer(q);
        q = '{8'h7F};
        send_buffer(q);
    endtask

    // One buffer per kind of format error.
    task automatic test_directed_malformed();
        logic [7:0] q[$];
        // Surrogate, then bytes dropped while skipping.
        q = '{8'hED, 8'hA0, 8'h80, 8'hFF, 8'h41};
        send_buffer(q);
        // Above the scalar range on the final byte.
        q = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_buffer(q);
        // Stray continuation where a lead is expected, on the final byte.
        q = '{8'h80};
        send_buffer(q);
        // Lead followed by a byte that is not a continuation.
        q = '{8'hE2, 8'h41};
        send_buffer(q);
        // Lead left without its continuation at the buffer's end.
        q = '{8'hC3};
        send_buffer(q);
        // Overlong two-byte form.
        q = '{8'hC1, 8'hBF};
        send_buffer(q);
    endtask

    task automatic test_random_buffers();
        logic [7:0] q[$];
        int         start_sent;
        start_sent = bytes_sent;
        while (bytes_sent - start_sent < RANDOM_BYTES) begin
            // Switch idling on and off now and then so that bursts show up too.
            if ($urandom_range(0, 7) == 0) in_idle_on   = !in_idle_on;
            if ($urandom_range(0, 7) == 0) out_stall_on = !out_stall_on;
            build_buffer(q);
            send_buffer(q);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_in    = 8'd0;
        in_ch.buffer_end = 1'b0;
        in_idle_on       = 1'b1;
        out_stall_on     = 1'b1;
        error_count      = 0;
        bytes_sent       = 0;
        live_bytes       = 0;
        buffers_sent     = 0;
        cp_seen          = 0;
        err_seen         = 0;
        end_seen         = 0;
        clear_decoder();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_valid();
        test_directed_malformed();
        test_random_buffers();
        in_ch.valid <= 1'b0;

        // Drain: wait for every predicted result, then give stray ones time to show.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers, %0d outside skipped regions.",
                 bytes_sent, buffers_sent, live_bytes);
        $display("Checked %0d code points, %0d format errors, %0d clean buffer ends.",
                 cp_seen, err_seen, end_seen);
        if (error_count == 0) begin
            $display("utf8_stream_validator_top_tb: done, clean");
        end else begin
            $display("utf8_stream_validator_top_tb: done, errors");
        end
        $finish;
    end

endmodule
